// ===== hw/rtl/key_heat_counter_colormap_defines.svh =====
// Assertion macros shared by the key heat counter RTL files.
`ifndef KEY_HEAT_COUNTER_COLORMAP_DEFINES_SVH
`define KEY_HEAT_COUNTER_COLORMAP_DEFINES_SVH

// Same-cycle check on clk, off while rst_n is low.
`define KHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check on clk, off while rst_n is low.
`define KHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/khc_pkg.sv =====
// Shared types and constants of the key heat counter.
package khc_pkg;

    // Operation codes
    localparam logic [1:0] OP_PRESS  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLOR_COUNT = 3'd0;
    localparam logic [2:0] CFG_PALETTE_0   = 3'd1;
    localparam logic [2:0] CFG_PALETTE_1   = 3'd2;
    localparam logic [2:0] CFG_PALETTE_2   = 3'd3;
    localparam logic [2:0] CFG_PALETTE_3   = 3'd4;

    localparam int          MAX_COLORS   = 4;
    localparam int          COUNT_W      = 16;
    localparam int          RGB_W        = 24;
    localparam int          DIVIDEND_W   = 24;
    localparam int          DIV_CNT_W    = 5;
    localparam logic [15:0] HALVE_MARK   = 16'h7FFF;
    localparam logic [2:0]  COLORS_RESET = 3'd4;

    localparam logic [RGB_W-1:0] PALETTE_RESET [4] = '{
        24'h000000, 24'h19FF19, 24'hFFFF19, 24'hFF1919
    };

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [COUNT_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [COUNT_W-1:0]    remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/khc_count_ram.sv =====
// Press count memory: one write port, one read port, registered read data.
module khc_count_ram
    import khc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic [AW-1:0]      raddr,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/khc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`include "key_heat_counter_colormap_defines.svh"

module khc_div
    import khc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [COUNT_W-1:0]    dvs_reg;

    logic [COUNT_W:0]      trial;
    logic                  fits;
    logic [COUNT_W:0]      diff;

    // One trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `KHC_ASSERT_NOW(a_div_rem_lt, done_reg, rem_reg < dvs_reg, "divider remainder not below divisor")

endmodule

// ===== hw/rtl/key_heat_counter_colormap.sv =====
// Top level of the key heat counter with color map.
//
// Usage: an operation (opcode, key_index) is taken at a rising edge with start
// high and busy low; busy then stays high until the operation is complete, unless it has no work.
// The user writes configuration (color_count, palette_0..3) through cfg_we,
// cfg_index and cfg_data only while busy is low; the block does not enforce it.
// Halving all counts (tick over threshold, or a press reaching 32767) walks
// the count memory key by key, with a read state and a write state per key.
// Reset map clears the memory one key a cycle.
// Render holds busy through setup (load, select, palette A, palette B; select is
// skipped for a zero count or one at the peak), then per color channel a multiply
// state, a divider start state and the shared 24-step one-bit-a-cycle divider.
// A render beat appears on key_out, red, green, blue for exactly one cycle
// with strobe high, the first cycle with busy low; there is no backpressure.
// Other operations and renders of keys beyond KEY_COUNT give no beat.
// After rst_n the block clears the count memory (busy high)
// and loads the default palette; configuration writes are taken meanwhile.
`include "key_heat_counter_colormap_defines.svh"

module key_heat_counter_colormap
    import khc_pkg::*;
#(
    parameter int KEY_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  key_index,
    output logic        strobe,
    output logic [5:0]  key_out,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [AW-1:0] LAST_KEY = AW'(KEY_COUNT - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_PRESS    = 4'd2;
    localparam logic [3:0] S_HALVE_RD = 4'd3;
    localparam logic [3:0] S_HALVE_WR = 4'd4;
    localparam logic [3:0] S_R_LOAD   = 4'd5;
    localparam logic [3:0] S_R_SEL    = 4'd6;
    localparam logic [3:0] S_R_PA     = 4'd7;
    localparam logic [3:0] S_R_PB     = 4'd8;
    localparam logic [3:0] S_R_MUL    = 4'd9;
    localparam logic [3:0] S_R_DIV    = 4'd10;
    localparam logic [3:0] S_R_WAIT   = 4'd11;

    // Configuration registers
    logic [2:0]       color_count_reg;
    logic [RGB_W-1:0] palette_reg [4];

    // Control registers
    logic [3:0]         state_reg,   state_next;
    logic [AW-1:0]      idx_reg,     idx_next;
    logic [COUNT_W-1:0] highest_reg, highest_next;
    logic               strobe_reg,  strobe_next;

    // Payload registers
    logic [AW-1:0]      key_addr_reg, key_addr_next;
    logic [17:0]        t_reg,        t_next;
    logic [1:0]         i1_reg,       i1_next;
    logic [1:0]         i2_reg,       i2_next;
    logic [COUNT_W-1:0] r_reg,        r_next;
    logic [COUNT_W-1:0] hd_reg,       hd_next;
    logic [RGB_W-1:0]   pa_reg,       pa_next;
    logic [RGB_W-1:0]   pb_reg,       pb_next;
    logic [1:0]         ch_reg,       ch_next;
    logic [7:0]         a_reg,        a_next;
    logic               neg_reg,      neg_next;
    logic [23:0]        prod_reg,     prod_next;
    logic [5:0]         key_out_reg,  key_out_next;
    logic [7:0]         red_reg,      red_next;
    logic [7:0]         green_reg,    green_next;
    logic [7:0]         blue_reg,     blue_next;

    // Memory and divider hookup
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Misc combinational
    logic               accept;
    logic               key_ok;
    logic [2:0]         n_used;
    logic [1:0]         nm1;
    logic [COUNT_W-1:0] cnt_inc;
    logic [RGB_W-1:0]   pal_sel;
    logic [7:0]         ch_a;
    logic [7:0]         ch_b;
    logic [7:0]         ch_diff;
    logic [1:0]         sel_i1;
    logic [17:0]        h1x;
    logic [17:0]        h2x;
    logic [7:0]         q8;
    logic [7:0]         ch_val;

    function automatic logic [7:0] chan_of(input logic [RGB_W-1:0] rgb, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            2'd0:    v = rgb[23:16];
            2'd1:    v = rgb[15:8];
            default: v = rgb[7:0];
        endcase
        return v;
    endfunction

    khc_count_ram #(
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    khc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= COLORS_RESET;
            for (int k = 0; k < 4; k++)
            begin
                palette_reg[k] <= PALETTE_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLOR_COUNT: color_count_reg <= cfg_data[2:0];
                CFG_PALETTE_0:   palette_reg[0]  <= cfg_data;
                CFG_PALETTE_1:   palette_reg[1]  <= cfg_data;
                CFG_PALETTE_2:   palette_reg[2]  <= cfg_data;
                CFG_PALETTE_3:   palette_reg[3]  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective color count and shared selections
    always_comb
    begin
        if (color_count_reg == 3'd0)
        begin
            n_used = 3'd1;
        end
        else if (color_count_reg > 3'(MAX_COLORS))
        begin
            n_used = 3'(MAX_COLORS);
        end
        else
        begin
            n_used = color_count_reg;
        end
        nm1     = 2'(n_used - 3'd1);
        accept  = start && (state_reg == S_IDLE);
        key_ok  = {3'b000, key_index} < 9'(KEY_COUNT);
        cnt_inc = ram_rdata + 16'd1;
        pal_sel = palette_reg[(state_reg == S_R_PB) ? i2_reg : i1_reg];
        ch_a    = chan_of(pa_reg, ch_reg);
        ch_b    = chan_of(pb_reg, ch_reg);
        ch_diff = (ch_b >= ch_a) ? (ch_b - ch_a) : (ch_a - ch_b);
        h1x     = {2'b00, highest_reg};
        h2x     = {1'b0, highest_reg, 1'b0};
        q8      = div_rsp.quotient[7:0];
        ch_val  = neg_reg ? (a_reg - q8 - {7'd0, |div_rsp.remainder}) : (a_reg + q8);
        if (t_reg < h1x)
        begin
            sel_i1 = 2'd0;
        end
        else if (t_reg < h2x)
        begin
            sel_i1 = 2'd1;
        end
        else
        begin
            sel_i1 = 2'd2;
        end
    end

    // Memory port steering
    always_comb
    begin
        ram_raddr = (state_reg == S_IDLE) ? AW'(key_index) : idx_reg;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_PRESS:
            begin
                ram_we    = 1'b1;
                ram_waddr = key_addr_reg;
                ram_wdata = cnt_inc;
            end
            S_HALVE_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, ram_rdata[COUNT_W-1:1]};
            end
            default: ;
        endcase
    end

    assign div_req.start    = (state_reg == S_R_DIV);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = hd_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        highest_next  = highest_reg;
        strobe_next   = 1'b0;
        key_addr_next = key_addr_reg;
        t_next        = t_reg;
        i1_next       = i1_reg;
        i2_next       = i2_reg;
        r_next        = r_reg;
        hd_next       = hd_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        ch_next       = ch_reg;
        a_next        = a_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        key_out_next  = key_out_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_addr_next = AW'(key_index);
                    key_out_next  = key_index;
                    idx_next      = '0;
                    case (opcode)
                        OP_PRESS:
                        begin
                            if (key_ok)
                            begin
                                state_next = S_PRESS;
                            end
                        end
                        OP_TICK:
                        begin
                            if (highest_reg > {4'd0, n_used, 9'd0})
                            begin
                                highest_next = {1'b0, highest_reg[COUNT_W-1:1]};
                                state_next   = S_HALVE_RD;
                            end
                        end
                        OP_RENDER:
                        begin
                            if (key_ok)
                            begin
                                state_next = S_R_LOAD;
                            end
                        end
                        default:
                        begin
                            highest_next = 16'd1;
                            state_next   = S_CLEAR;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_KEY)
                begin
                    state_next = S_IDLE;
                end
            end

            S_PRESS:
            begin
                state_next = S_IDLE;
                if (highest_reg < cnt_inc)
                begin
                    highest_next = cnt_inc;
                    if (cnt_inc == HALVE_MARK)
                    begin
                        highest_next = {1'b0, cnt_inc[COUNT_W-1:1]};
                        state_next   = S_HALVE_RD;
                    end
                end
            end

            S_HALVE_RD:
            begin
                state_next = S_HALVE_WR;
            end

            S_HALVE_WR:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == LAST_KEY) ? S_IDLE : S_HALVE_RD;
            end

            // Count in hand: settle the trivial ends, else form c*(n-1)
            S_R_LOAD:
            begin
                r_next  = '0;
                hd_next = 16'd1;
                if ((ram_rdata == 16'd0) || (highest_reg == 16'd0))
                begin
                    i1_next    = 2'd0;
                    i2_next    = 2'd0;
                    state_next = S_R_PA;
                end
                else if (ram_rdata >= highest_reg)
                begin
                    i1_next    = nm1;
                    i2_next    = nm1;
                    state_next = S_R_PA;
                end
                else
                begin
                    case (nm1)
                        2'd0:    t_next = '0;
                        2'd1:    t_next = {2'b00, ram_rdata};
                        2'd2:    t_next = {1'b0, ram_rdata, 1'b0};
                        default: t_next = {2'b00, ram_rdata} + {1'b0, ram_rdata, 1'b0};
                    endcase
                    state_next = S_R_SEL;
                end
            end

            // Segment index and position inside it
            S_R_SEL:
            begin
                i1_next = sel_i1;
                i2_next = (sel_i1 == nm1) ? sel_i1 : (sel_i1 + 2'd1);
                hd_next = highest_reg;
                case (sel_i1)
                    2'd0:    r_next = t_reg[COUNT_W-1:0];
                    2'd1:    r_next = 16'(t_reg - h1x);
                    default: r_next = 16'(t_reg - h2x);
                endcase
                state_next = S_R_PA;
            end

            S_R_PA:
            begin
                pa_next    = pal_sel;
                state_next = S_R_PB;
            end

            S_R_PB:
            begin
                pb_next    = pal_sel;
                ch_next    = 2'd0;
                state_next = S_R_MUL;
            end

            S_R_MUL:
            begin
                a_next     = ch_a;
                neg_next   = ch_b < ch_a;
                prod_next  = {16'd0, ch_diff} * {8'd0, r_reg};
                state_next = S_R_DIV;
            end

            S_R_DIV:
            begin
                state_next = S_R_WAIT;
            end

            S_R_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (ch_reg)
                        2'd0:    red_next   = ch_val;
                        2'd1:    green_next = ch_val;
                        default: blue_next  = ch_val;
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_R_MUL;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            highest_reg <= 16'd1;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            highest_reg <= highest_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_addr_reg <= key_addr_next;
        t_reg        <= t_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        r_reg        <= r_next;
        hd_reg       <= hd_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        ch_reg       <= ch_next;
        a_reg        <= a_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        key_out_reg  <= key_out_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign key_out = key_out_reg;
    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;

    `KHC_ASSERT_NEXT(a_last_chan_beat, (state_reg == S_R_WAIT) && div_rsp.done && (ch_reg == 2'd2), strobe_reg, "render finished without a beat")
    `KHC_ASSERT_NOW(a_beat_idle, strobe_reg, state_reg == S_IDLE, "beat while still busy")
    `KHC_ASSERT_NOW(a_highest_mark, 1'b1, highest_reg != HALVE_MARK, "highest count left at halving mark")
    `KHC_ASSERT_NOW(a_pos_below_div, state_reg == S_R_MUL, r_reg < hd_reg, "blend position not below divisor")

endmodule

// ===== bench/heat_color_checker.sv =====
// Scoreboard for the key heat counter: tracks counts, predicts render colors, checks beats.
module heat_color_checker
    import khc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  key_index,
    input  logic        strobe,
    input  logic [5:0]  key_out,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          outstanding,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = 64;

    typedef struct packed {
        logic [5:0] key;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_beat_t;

    // Mirror of the block's state and registers
    logic [COUNT_W-1:0] heat [KEYS];
    logic [COUNT_W-1:0] peak;
    logic [2:0]         color_reg;
    logic [RGB_W-1:0]   palette [MAX_COLORS];
    color_beat_t        due_colors [$];

    initial errors = 0;

    task automatic report(input string msg);
        $display("checker: %s at %0t", msg, $time);
        errors++;
    endtask

    // Out-of-range color counts are clamped to 1..MAX_COLORS
    function automatic int unsigned colors_in_use();
        int unsigned n;
        n = color_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_COLORS)
            n = MAX_COLORS;
        return n;
    endfunction

    task automatic halve_counts();
        for (int k = 0; k < KEYS; k++)
            heat[k] = heat[k] >> 1;
        peak = peak >> 1;
    endtask

    task automatic clear_counts();
        for (int k = 0; k < KEYS; k++)
            heat[k] = '0;
        peak = 16'd1;
    endtask

    // Floor of a + (b - a) * r / h, exact in integers
    function automatic logic [7:0] mix(input int unsigned a, input int unsigned b,
                                       input int unsigned r, input int unsigned h);
        if (b >= a)
            return 8'(a + ((b - a) * r) / h);
        return 8'(a - ((a - b) * r + h - 1) / h);
    endfunction

    // Color of one key at position count/peak along the palette
    function automatic color_beat_t predict_color(input logic [5:0] key);
        int unsigned n, c, h, t, lo, hi, r, hd;
        color_beat_t beat;
        n  = colors_in_use();
        c  = heat[key];
        h  = peak;
        lo = 0;
        hi = 0;
        r  = 0;
        hd = 1;
        if (c == 0 || h == 0)
        begin
            lo = 0;
            hi = 0;
        end
        else if (c >= h)
        begin
            lo = n - 1;
            hi = n - 1;
        end
        else
        begin
            t  = c * (n - 1);
            lo = t / h;
            r  = t - lo * h;
            hd = h;
            hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
        end
        beat.key   = key;
        beat.red   = mix(palette[lo][23:16], palette[hi][23:16], r, hd);
        beat.green = mix(palette[lo][15:8], palette[hi][15:8], r, hd);
        beat.blue  = mix(palette[lo][7:0], palette[hi][7:0], r, hd);
        return beat;
    endfunction

    // Watch config writes, result beats and accepted operations
    always @(posedge clk or negedge rst_n)
    begin
        logic [COUNT_W-1:0] bumped;
        color_beat_t        want;
        if (!rst_n)
        begin
            clear_counts();
            color_reg = COLORS_RESET;
            for (int i = 0; i < MAX_COLORS; i++)
                palette[i] = PALETTE_RESET[i];
            due_colors.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLOR_COUNT: color_reg  = cfg_data[2:0];
                    CFG_PALETTE_0:   palette[0] = cfg_data;
                    CFG_PALETTE_1:   palette[1] = cfg_data;
                    CFG_PALETTE_2:   palette[2] = cfg_data;
                    CFG_PALETTE_3:   palette[3] = cfg_data;
                    default: ;
                endcase
            end

            // beat out: compare against the oldest pending render
            if (strobe)
            begin
                if (due_colors.size() == 0)
                    report($sformatf("render beat for key %0d with none pending", key_out));
                else
                begin
                    want = due_colors.pop_front();
                    if (key_out !== want.key)
                        report($sformatf("key_out %0d, want %0d", key_out, want.key));
                    if (red !== want.red)
                        report($sformatf("key %0d red %0d, want %0d", want.key, red, want.red));
                    if (green !== want.green)
                        report($sformatf("key %0d green %0d, want %0d",
                                         want.key, green, want.green));
                    if (blue !== want.blue)
                        report($sformatf("key %0d blue %0d, want %0d",
                                         want.key, blue, want.blue));
                end
            end

            // beat in: every 6-bit key is below KEY_COUNT, so no render is dropped
            if (start && !busy)
            begin
                case (opcode)
                    OP_PRESS:
                    begin
                        bumped = heat[key_index] + 16'd1;
                        heat[key_index] = bumped;
                        if (peak < bumped)
                        begin
                            peak = bumped;
                            if (peak == HALVE_MARK)
                                halve_counts();
                        end
                    end
                    OP_TICK:
                    begin
                        if (32'(peak) > (colors_in_use() << 9))
                            halve_counts();
                    end
                    OP_RENDER: due_colors.push_back(predict_color(key_index));
                    OP_CLEAR:  clear_counts();
                    default: ;
                endcase
            end
            outstanding = due_colors.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the key heat counter bench: clock, reset, operation and config stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import khc_pkg::*;

    localparam int RANDOM_PICKS  = 1140;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 5000;

    localparam logic [2:0] REG_ORDER [5] = '{
        CFG_COLOR_COUNT, CFG_PALETTE_0, CFG_PALETTE_1, CFG_PALETTE_2, CFG_PALETTE_3
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [5:0]  key_index;
    logic        strobe;
    logic [5:0]  key_out;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          outstanding;
    int          errors;
    int          stall_cycles = 0;
    bit          gaps_on = 1'b1;

    key_heat_counter_colormap u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .key_index (key_index),
        .strobe    (strobe),
        .key_out   (key_out),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heat_color_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key_index   (key_index),
        .strobe      (strobe),
        .key_out     (key_out),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: too long without any beat in or out
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [23:0] pick_rgb();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 24'h000000;
        if (roll < 30)
            return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    // Called at a rising edge; returns at the edge that takes the beat
    task automatic issue(input logic [1:0] op, input logic [5:0] key);
        start     <= 1'b1;
        opcode    <= op;
        key_index <= key;
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
    endtask

    task automatic idle(input int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(input logic [1:0] op, input logic [5:0] key);
        issue(op, key);
        idle(gaps_on ? pick_gap() : 0);
    endtask

    task automatic press_burst(input logic [5:0] key, input int unsigned n);
        repeat (n) issue(OP_PRESS, key);
    endtask

    // Hold off until the block is idle and every render beat has come back
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (busy !== 1'b0 || outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers, only while idle
    task automatic load_colors(input logic [2:0] count, input logic [23:0] p0,
                               input logic [23:0] p1, input logic [23:0] p2,
                               input logic [23:0] p3);
        logic [23:0] vals [5];
        vals = '{{21'd0, count}, p0, p1, p2, p3};
        wait_idle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random mix of operations, keys biased toward a few hot ones
    task automatic random_mix(input int picks);
        int unsigned roll;
        logic [5:0]  key;
        logic [5:0]  hot [4];
        foreach (hot[i])
            hot[i] = 6'($urandom_range(0, 63));
        for (int p = 0; p < picks; p++)
        begin
            if (p % 100 == 0)
                gaps_on = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 99) < 60)
                key = hot[$urandom_range(0, 3)];
            else
                key = 6'($urandom_range(0, 63));
            roll = $urandom_range(0, 99);
            if (roll < 1)
                press_burst(key, $urandom_range(4, 16));
            else if (roll < 50)
                send(OP_PRESS, key);
            else if (roll < 84)
                send(OP_RENDER, key);
            else if (roll < 98)
                send(OP_TICK, key);
            else
                send(OP_CLEAR, key);
        end
    endtask

    initial
    begin
        logic [2:0] phase_colors [PHASES];
        phase_colors = '{3'd3, 3'd1, 3'd6, 3'd2, 3'd0, 3'd5};
        start     <= 1'b0;
        opcode    <= OP_PRESS;
        key_index <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_COLOR_COUNT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default palette: zero count, count at peak, midway blend, extreme keys
        send(OP_RENDER, 6'd0);
        send(OP_PRESS, 6'd0);
        send(OP_RENDER, 6'd0);
        send(OP_PRESS, 6'd63);
        send(OP_PRESS, 6'd63);
        send(OP_RENDER, 6'd0);
        send(OP_RENDER, 6'd63);
        send(OP_TICK, 6'd63);
        send(OP_PRESS, 6'd0);
        send(OP_RENDER, 6'd0);
        send(OP_CLEAR, 6'd0);
        send(OP_RENDER, 6'd63);

        // Single color, then color counts below and above the usable range
        load_colors(3'd1, pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb());
        send(OP_PRESS, 6'd5);
        send(OP_RENDER, 6'd5);
        send(OP_RENDER, 6'd0);
        load_colors(3'd0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
        send(OP_RENDER, 6'd5);
        send(OP_PRESS, 6'd6);
        send(OP_RENDER, 6'd6);
        load_colors(3'd7, 24'hFFFFFF, 24'h808080, 24'h010101, 24'h000000);
        send(OP_RENDER, 6'd5);
        send(OP_PRESS, 6'd5);
        send(OP_PRESS, 6'd5);
        send(OP_RENDER, 6'd6);

        // Tick threshold with color count 0, used as one color: 512 holds, 513 halves
        load_colors(3'd0, 24'hFFFFFF, 24'h000000, pick_rgb(), pick_rgb());
        send(OP_CLEAR, 6'd0);
        press_burst(6'd9, 512);
        send(OP_TICK, 6'd0);
        send(OP_RENDER, 6'd9);
        send(OP_PRESS, 6'd9);
        press_burst(6'd10, 30);
        send(OP_TICK, 6'd0);
        send(OP_RENDER, 6'd9);
        send(OP_RENDER, 6'd10);
        send(OP_RENDER, 6'd11);

        // Four colors: blends inside the segments, tick below the threshold
        load_colors(3'd4, pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb());
        send(OP_CLEAR, 6'd0);
        press_burst(6'd21, 90);
        press_burst(6'd20, 40);
        send(OP_TICK, 6'd0);
        send(OP_RENDER, 6'd20);
        send(OP_RENDER, 6'd21);
        send(OP_RENDER, 6'd22);
        send(OP_PRESS, 6'd21);
        send(OP_RENDER, 6'd20);
        send(OP_RENDER, 6'd21);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            load_colors(phase_colors[ph], pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb());
            random_mix(RANDOM_PICKS / PHASES);
        end

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
